@@ rtl/uart_command_frame_parser_core_macros.svh @@
// Assertion helpers shared by the frame parser RTL.
// Each macro expands to one labeled concurrent assertion on clk_i, disabled in reset.
`ifndef UART_COMMAND_FRAME_PARSER_CORE_MACROS_SVH
`define UART_COMMAND_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define UCFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UCFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ucfp_pkg.sv @@
// ----------------------------------------------------------------------------
// ucfp_pkg
// Widths, register indexes, reset values and controller/datapath bundles
// of the command frame parser.
// ----------------------------------------------------------------------------
package ucfp_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned LEN_W             = 5;
  localparam int unsigned IDX_W             = 4;
  localparam int unsigned CFG_IDX_W         = 8;
  localparam int unsigned PAYLOAD_DEPTH_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 8'd1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h55;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 5'd16;

  // Controller to datapath.
  typedef struct packed {
    logic cap_cmd;   // take command byte, seed checksum
    logic cap_len;   // take length byte, clear count
    logic cap_data;  // store payload byte, advance count
    logic emit_clr;  // restart emit index
    logic rd_req;    // read payload entry at emit index
    logic load_out;  // fill output register
    logic adv_emit;  // advance emit index
  } ucfp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_hit;
    logic len_too_big;
    logic len_byte_zero;
    logic data_done;
    logic sum_match;
    logic len_zero;
    logic emit_last;
    logic out_free;
  } ucfp_sts_t;

endpackage

@@ rtl/ucfp_intf.sv @@
// ----------------------------------------------------------------------------
// ucfp channel interfaces
// Received byte stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface ucfp_rx_if import ucfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfp_res_if import ucfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_cmd;
  logic [LEN_W-1:0]  out_len;
  logic [IDX_W-1:0]  out_index;
  logic [BYTE_W-1:0] out_data;
  logic              out_last;

  modport source (output valid, output out_cmd, output out_len, output out_index,
                  output out_data, output out_last, input ready);
  modport sink   (input valid, input out_cmd, input out_len, input out_index,
                  input out_data, input out_last, output ready);
endinterface

interface ucfp_cfg_if import ucfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ucfp_ram.sv @@
// ----------------------------------------------------------------------------
// ucfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ucfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ucfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ucfp_ctrl
// Frame parser sequencer: hunt, command, length, payload, checksum, emit.
// ----------------------------------------------------------------------------
`include "uart_command_frame_parser_core_macros.svh"

module ucfp_ctrl import ucfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rx_valid_i,
  output logic      rx_ready_o,
  input  ucfp_sts_t sts_i,
  output ucfp_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_HUNT = 7'b0000001,
    ST_CMD  = 7'b0000010,
    ST_LEN  = 7'b0000100,
    ST_DATA = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_RD   = 7'b0100000,
    ST_LOAD = 7'b1000000
  } ucfp_state_e;

  ucfp_state_e state_q, state_d;
  logic        rx_xfer;

  // take bytes in every receive state, hold the input while emitting
  assign rx_ready_o = (state_q == ST_HUNT) || (state_q == ST_CMD) || (state_q == ST_LEN) ||
                      (state_q == ST_DATA) || (state_q == ST_SUM);
  assign rx_xfer    = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_HUNT: begin
        if (rx_xfer && sts_i.start_hit) begin
          state_d = ST_CMD;
        end
      end
      ST_CMD: begin
        if (rx_xfer) begin
          cmd_o.cap_cmd = 1'b1;
          state_d       = ST_LEN;
        end
      end
      ST_LEN: begin
        if (rx_xfer) begin
          if (sts_i.len_too_big) begin
            state_d = ST_HUNT;
          end else begin
            cmd_o.cap_len = 1'b1;
            state_d       = sts_i.len_byte_zero ? ST_SUM : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (rx_xfer) begin
          cmd_o.cap_data = 1'b1;
          if (sts_i.data_done) begin
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (rx_xfer) begin
          if (sts_i.sum_match) begin
            cmd_o.emit_clr = 1'b1;
            state_d        = sts_i.len_zero ? ST_LOAD : ST_RD;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_req = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register can take the next result
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_HUNT;
          end else begin
            cmd_o.adv_emit = 1'b1;
            state_d        = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  `UCFP_ASSERT_IMP(a_load_needs_free, cmd_o.load_out, sts_i.out_free, "output overwritten")
  `UCFP_ASSERT_NXT(a_read_then_load, state_q == ST_RD, state_q == ST_LOAD, "read not followed by load")
  `UCFP_ASSERT_IMP(a_no_rx_in_emit, state_q == ST_RD || state_q == ST_LOAD, !rx_ready_o, "rx open during emit")

endmodule

@@ rtl/ucfp_datapath.sv @@
// ----------------------------------------------------------------------------
// ucfp_datapath
// Config registers, frame fields, checksum, payload store and output register.
// ----------------------------------------------------------------------------
`include "uart_command_frame_parser_core_macros.svh"

module ucfp_datapath import ucfp_pkg::*; #(
  parameter int unsigned PayloadDepth = PAYLOAD_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  ucfp_cmd_t            cmd_i,
  output ucfp_sts_t            sts_o,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output logic [BYTE_W-1:0]    out_cmd_o,
  output logic [LEN_W-1:0]     out_len_o,
  output logic [IDX_W-1:0]     out_index_o,
  output logic [BYTE_W-1:0]    out_data_o,
  output logic                 out_last_o
);

  localparam int unsigned AddrW = (PayloadDepth > 1) ? $clog2(PayloadDepth) : 1;
  localparam logic [BYTE_W-1:0] DepthB = BYTE_W'(PayloadDepth);

  logic [BYTE_W-1:0] start_byte_q;
  logic [LEN_W-1:0]  max_len_q;
  logic [BYTE_W-1:0] command_q;
  logic [LEN_W-1:0]  frame_len_q;
  logic [LEN_W-1:0]  cnt_q;
  logic [BYTE_W-1:0] sum_q;
  logic [LEN_W-1:0]  idx_q;
  logic              res_valid_q;
  logic [BYTE_W-1:0] out_cmd_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [IDX_W-1:0]  out_index_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_last_q;

  logic [BYTE_W-1:0] max_len_w;
  logic [BYTE_W-1:0] limit;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_rdata;

  assign max_len_w = {{(BYTE_W-LEN_W){1'b0}}, max_len_q};
  // a limit above the store depth acts as the depth
  assign limit     = (max_len_w > DepthB) ? DepthB : max_len_w;

  always_comb begin
    sts_o.start_hit     = (rx_byte_i == start_byte_q);
    sts_o.len_too_big   = (rx_byte_i > limit);
    sts_o.len_byte_zero = (rx_byte_i == '0);
    sts_o.data_done     = (({1'b0, cnt_q} + 6'd1) >= {1'b0, frame_len_q});
    sts_o.sum_match     = (sum_q == rx_byte_i);
    sts_o.len_zero      = (frame_len_q == '0);
    sts_o.emit_last     = (frame_len_q == '0) ||
                          (({1'b0, idx_q} + 6'd1) == {1'b0, frame_len_q});
    sts_o.out_free      = !res_valid_q || res_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      max_len_q    <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_START_BYTE) begin
        start_byte_q <= cfg_data_i;
      end else if (cfg_index_i == REG_MAX_LEN) begin
        max_len_q <= cfg_data_i[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_cmd) begin
      command_q <= rx_byte_i;
      sum_q     <= rx_byte_i;
    end
    if (cmd_i.cap_len) begin
      frame_len_q <= rx_byte_i[LEN_W-1:0];
      cnt_q       <= '0;
      sum_q       <= sum_q + rx_byte_i;
    end
    if (cmd_i.cap_data) begin
      cnt_q <= cnt_q + 5'd1;
      sum_q <= sum_q + rx_byte_i;
    end
    if (cmd_i.emit_clr) begin
      idx_q <= '0;
    end else if (cmd_i.adv_emit) begin
      idx_q <= idx_q + 5'd1;
    end
    if (cmd_i.load_out) begin
      out_cmd_q   <= command_q;
      out_len_q   <= frame_len_q;
      out_index_q <= idx_q[IDX_W-1:0];
      out_data_q  <= (frame_len_q == '0) ? '0 : ram_rdata;
      out_last_q  <= sts_o.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // drop payload bytes beyond the store
  assign ram_we = cmd_i.cap_data && ({{(BYTE_W-LEN_W){1'b0}}, cnt_q} < DepthB);

  ucfp_ram #(
    .Width (BYTE_W),
    .Depth (PayloadDepth)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(cnt_q)),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_req),
    .raddr_i (AddrW'(idx_q)),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = res_valid_q;
  assign out_cmd_o   = out_cmd_q;
  assign out_len_o   = out_len_q;
  assign out_index_o = out_index_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  `UCFP_ASSERT_IMP(a_cnt_bound, cmd_i.cap_data, cnt_q < frame_len_q, "payload count overran length")

endmodule

@@ rtl/uart_command_frame_parser_core.sv @@
// Command frame parser for a received serial byte stream.
// rx_i: one received byte per transfer. The parser hunts for the start byte,
//   then takes command, length, length payload bytes and a checksum byte
//   (8-bit wrapping sum of command, length and payload).
// res_o: one result per payload byte of a frame with a good checksum, or a
//   single result with zero data for an empty frame; out_last marks the end.
// cfg_i: register 0 is the start byte, register 1 the largest length. Write
//   only while idle; the channel is always ready.
// After a good checksum the parser reads the payload entry at the emit index,
// then loads it into the output register; an empty frame loads at once.
// Following results repeat the read and load, paced by the registered read of
// the payload RAM. rx_i.ready is low while a frame is emitted, so the input
// is held until the last result is loaded.
// A stalled receiver holds the output register and the emit sequence; once
// the last result is loaded the parser takes bytes again even if it waits.
// Reset puts the parser in hunt, clears the output valid and loads the
// registers with start byte 0x55 and length limit 16. No clearing pass.
// ----------------------------------------------------------------------------
// uart_command_frame_parser_core
// Top level: controller, datapath and channel hookup.
// ----------------------------------------------------------------------------
module uart_command_frame_parser_core import ucfp_pkg::*; #(
  parameter int unsigned PayloadDepth = PAYLOAD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ucfp_rx_if.sink    rx_i,
  ucfp_res_if.source res_o,
  ucfp_cfg_if.sink   cfg_i
);

  ucfp_cmd_t cmd;
  ucfp_sts_t sts;
  logic      rx_ready;

  ucfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ucfp_datapath #(
    .PayloadDepth (PayloadDepth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_i.rx_byte),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .out_cmd_o   (res_o.out_cmd),
    .out_len_o   (res_o.out_len),
    .out_index_o (res_o.out_index),
    .out_data_o  (res_o.out_data),
    .out_last_o  (res_o.out_last)
  );

  assign rx_i.ready  = rx_ready;
  assign cfg_i.ready = 1'b1;

endmodule

@@ tb/sv/uart_command_frame_parser_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_command_frame_parser_core_tb
// Self-checking bench for the command frame parser. Streams framed, corrupted,
// oversized and truncated byte sequences with random bursts and gaps, stalls
// the result side on random patterns, predicts every result from a local
// parser model and compares each result field by field.
// ----------------------------------------------------------------------------
module uart_command_frame_parser_core_tb;
  import ucfp_pkg::*;

  localparam int unsigned DEPTH         = PAYLOAD_DEPTH_DEF;
  localparam int unsigned RAND_BYTES    = 400;
  localparam int unsigned PHASE_BYTES   = 45;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam longint      TIMEOUT_NS    = 6_000_000;
  localparam logic [BYTE_W-1:0] SB      = START_BYTE_RST;

  typedef enum logic [2:0] {PH_HUNT, PH_CMD, PH_LEN, PH_DATA, PH_SUM} parse_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] cmd;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_beat_t;

  logic clk_i;
  logic rst_ni;

  ucfp_rx_if  rx_if ();
  ucfp_res_if res_if ();
  ucfp_cfg_if cfg_if ();

  uart_command_frame_parser_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Parser model state and register copies
  logic [BYTE_W-1:0] cfg_start;
  logic [LEN_W-1:0]  cfg_max_len;
  parse_phase_e      ph;
  logic [BYTE_W-1:0] cur_cmd;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  rcv_cnt;
  logic [BYTE_W-1:0] run_sum;
  logic [BYTE_W-1:0] payload_mem [DEPTH];

  logic [BYTE_W-1:0] rx_byte_q [$];
  frame_beat_t       beat_q [$];
  int unsigned       fail_cnt;
  int unsigned       frame_bytes;

  // Idling controls
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned gap_max;
  int unsigned ready_mode;
  logic [31:0] stall_pat;
  logic [4:0]  stall_pos;

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned len_limit();
    return (cfg_max_len > DEPTH) ? DEPTH : cfg_max_len;
  endfunction

  function automatic void advance_parser(input logic [BYTE_W-1:0] b);
    frame_beat_t beat;
    int unsigned i;
    case (ph)
      PH_CMD: begin
        cur_cmd = b;
        run_sum = b;
        ph      = PH_LEN;
      end
      PH_LEN: begin
        // the whole byte is held against the limit, not just its low bits
        if (b > len_limit()) begin
          ph = PH_HUNT;
        end else begin
          cur_len = b[LEN_W-1:0];
          rcv_cnt = '0;
          run_sum = run_sum + b;
          ph      = (cur_len == 0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        payload_mem[rcv_cnt[IDX_W-1:0]] = b;
        rcv_cnt = rcv_cnt + 1'b1;
        run_sum = run_sum + b;
        if (rcv_cnt >= cur_len) ph = PH_SUM;
      end
      PH_SUM: begin
        if (run_sum == b) begin
          if (cur_len == 0) begin
            beat.cmd   = cur_cmd;
            beat.len   = cur_len;
            beat.index = '0;
            beat.data  = '0;
            beat.last  = 1'b1;
            beat_q.push_back(beat);
          end else begin
            for (i = 0; i < cur_len; i++) begin
              beat.cmd   = cur_cmd;
              beat.len   = cur_len;
              beat.index = i[IDX_W-1:0];
              beat.data  = payload_mem[i];
              beat.last  = (i + 1 == cur_len);
              beat_q.push_back(beat);
            end
          end
        end
        ph      = PH_HUNT;
        cur_cmd = '0;
        cur_len = '0;
        rcv_cnt = '0;
        run_sum = '0;
      end
      default: begin
        if (b == cfg_start) begin
          ph      = PH_CMD;
          run_sum = '0;
          rcv_cnt = '0;
        end
      end
    endcase
  endfunction

  // Build one frame at the current start byte; stop after the length byte when
  // it is over the limit, or partway through the payload when truncating.
  function automatic void queue_frame(input logic [BYTE_W-1:0] cmd,
                                      input logic [BYTE_W-1:0] len_byte,
                                      input bit bad_sum, input bit truncate);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] pb;
    int unsigned       n;
    int unsigned       i;
    sum = cmd + len_byte;
    rx_byte_q.push_back(cfg_start);
    rx_byte_q.push_back(cmd);
    rx_byte_q.push_back(len_byte);
    frame_bytes += 3;
    if (len_byte > len_limit()) return;
    n = truncate ? $urandom_range(0, len_byte) : len_byte;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       pb = 8'h00;
        1:       pb = 8'hFF;
        default: pb = 8'($urandom_range(0, 255));
      endcase
      rx_byte_q.push_back(pb);
      sum = sum + pb;
    end
    frame_bytes += n;
    if (truncate) return;
    rx_byte_q.push_back(bad_sum ? 8'(sum + $urandom_range(1, 255)) : sum);
    frame_bytes++;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_START_BYTE) begin
      cfg_start = val;
    end else if (idx == REG_MAX_LEN) begin
      cfg_max_len = val[LEN_W-1:0];
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Drain everything, then feed filler until the parser is back to hunting.
  task automatic finish_phase();
    while (rx_byte_q.size() != 0 || beat_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (ph != PH_HUNT) begin
      rx_byte_q.push_back(8'h00);
      while (rx_byte_q.size() != 0 || beat_q.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end
  endtask

  // Byte transfer: advance the model, pop the queue, schedule the next gap
  always @(posedge clk_i) begin
    if (rst_ni && rx_if.valid && rx_if.ready) begin
      advance_parser(rx_if.rx_byte);
      void'(rx_byte_q.pop_front());
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 8);
        gap_left   = $urandom_range(0, gap_max);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
        rx_if.valid <= 1'b0;
      end else if (rx_byte_q.size() > 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= rx_byte_q[0];
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      res_if.ready <= stall_pat[stall_pos];
      stall_pos = stall_pos + 1'b1;
      if (stall_pos == 0) begin
        case (ready_mode)
          0:       stall_pat = '1;
          1:       stall_pat = $urandom | 32'h1;
          default: stall_pat = ($urandom & $urandom & $urandom) | 32'h1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (beat_q.size() == 0) begin
        $error("unexpected result: out_cmd %0h out_len %0d out_index %0d out_data %0h",
               res_if.out_cmd, res_if.out_len, res_if.out_index, res_if.out_data);
        fail_cnt++;
      end else begin
        want = beat_q.pop_front();
        if (res_if.out_cmd !== want.cmd) begin
          $error("out_cmd mismatch: expected %0h, actual %0h", want.cmd, res_if.out_cmd);
          fail_cnt++;
        end
        if (res_if.out_len !== want.len) begin
          $error("out_len mismatch: expected %0d, actual %0d", want.len, res_if.out_len);
          fail_cnt++;
        end
        if (res_if.out_index !== want.index) begin
          $error("out_index mismatch: expected %0d, actual %0d", want.index,
                 res_if.out_index);
          fail_cnt++;
        end
        if (res_if.out_data !== want.data) begin
          $error("out_data mismatch: expected %0h, actual %0h", want.data, res_if.out_data);
          fail_cnt++;
        end
        if (res_if.out_last !== want.last) begin
          $error("out_last mismatch: expected %0b, actual %0b", want.last, res_if.out_last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [BYTE_W-1:0] start_val;
    logic [BYTE_W-1:0] max_val;
    int unsigned       phase_end;
    int unsigned       lim;
    int unsigned       p;

    rst_ni         = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    cfg_start      = START_BYTE_RST;
    cfg_max_len    = MAX_LEN_RST;
    ph             = PH_HUNT;
    cur_cmd        = '0;
    cur_len        = '0;
    rcv_cnt        = '0;
    run_sum        = '0;
    foreach (payload_mem[i]) payload_mem[i] = '0;
    fail_cnt       = 0;
    frame_bytes    = 0;
    burst_left     = 4;
    gap_left       = 0;
    gap_max        = 6;
    ready_mode     = 1;
    stall_pat      = '1;
    stall_pos      = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed bytes at the reset register values
    rx_byte_q = {8'h00, 8'hFF,                        // noise while hunting
                 SB, SB, 8'h00, SB,                   // empty frame, command is start byte
                 SB, 8'hFF, 8'h00, 8'h00,             // empty frame, bad checksum
                 SB, 8'h01, 8'h11,                    // length one above the limit
                 SB, 8'h02, 8'h21,                    // length whose low bits would pass
                 SB, 8'h80, 8'hFF,                    // length byte all ones
                 SB, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h00};
    finish_phase();

    p = 0;
    while (frame_bytes < RAND_BYTES) begin
      case (p)
        0:       start_val = 8'h00;
        1:       start_val = 8'hFF;
        2:       start_val = START_BYTE_RST;
        default: start_val = 8'($urandom_range(0, 255));
      endcase
      case (p)
        0:       max_val = 8'd0;
        1:       max_val = 8'd31;
        2:       max_val = 8'd1;
        3:       max_val = 8'd16;
        default: max_val = 8'($urandom_range(0, 31));
      endcase
      write_reg(REG_START_BYTE, start_val);
      write_reg(REG_MAX_LEN, max_val);
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 4;
        default: gap_max = 24;
      endcase
      ready_mode = $urandom_range(0, 2);
      lim        = len_limit();
      phase_end  = frame_bytes + PHASE_BYTES;

      // open each setting with a frame at the length limit
      queue_frame(8'($urandom_range(0, 255)), 8'(lim), 1'b0, 1'b0);
      while (frame_bytes < phase_end) begin
        case ($urandom_range(0, 19))
          0, 1: rx_byte_q.push_back(8'($urandom_range(0, 255)));
          2:    queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(lim + 1, 255)),
                            1'b0, 1'b0);
          3:    queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, lim)),
                            1'b0, 1'b1);
          4, 5: queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, lim)),
                            1'b1, 1'b0);
          default: begin
            queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, lim)),
                        1'b0, 1'b0);
          end
        endcase
      end
      finish_phase();
      p++;
    end

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
